FILE: rtl/ncs_pkg.sv
// Package for the nullable column store: field widths, operation and status
// codes, element kinds, register indexes and the accumulator control struct.
// No dependencies.
`default_nettype none

package ncs_pkg;

    localparam int ELEM_W      = 64;
    localparam int OP_W        = 2;
    localparam int IDX_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int CNT_W       = 11;
    localparam int KIND_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int DEPTH_DEFAULT = 1024;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_VALUE = 2'd0,
        OP_WRITE_NULL  = 2'd1,
        OP_READ        = 2'd2,
        OP_REDUCE      = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_INDEX_RANGE  = 2'd1,
        ST_NULL_DENIED  = 2'd2,
        ST_VALUE_RANGE  = 2'd3
    } status_t;

    localparam logic [KIND_W-1:0] KIND_INT8  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INT16 = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INT32 = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INT64 = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BOOL  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_KIND     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NULLS_ALLOWED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_LENGTH    = 2'd2;

    typedef struct packed {
        logic clear;
        logic enable;
        logic bool_mode;
    } acc_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/ncs_in_if.sv
// Input channel of the column store: valid/ready handshake and operation fields.
// Depends on ncs_pkg.
`default_nettype none

interface ncs_in_if;
    logic                              valid;
    logic                              ready;
    logic [ncs_pkg::OP_W-1:0]          opcode;
    logic [ncs_pkg::IDX_W-1:0]         elem_index;
    logic signed [ncs_pkg::ELEM_W-1:0] write_value;

    modport source (output valid, output opcode, output elem_index, output write_value,
                    input ready);
    modport sink   (input valid, input opcode, input elem_index, input write_value,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/ncs_out_if.sv
// Result channel of the column store: valid/ready handshake and result fields.
// Depends on ncs_pkg.
`default_nettype none

interface ncs_out_if;
    logic                              valid;
    logic                              ready;
    logic [ncs_pkg::STATUS_W-1:0]      status;
    logic signed [ncs_pkg::ELEM_W-1:0] read_value;
    logic                              read_null;
    logic signed [ncs_pkg::ELEM_W-1:0] total;
    logic signed [ncs_pkg::ELEM_W-1:0] smallest;
    logic signed [ncs_pkg::ELEM_W-1:0] largest;
    logic [ncs_pkg::CNT_W-1:0]         valid_count;
    logic                              any_valid;

    modport source (output valid, output status, output read_value, output read_null,
                    output total, output smallest, output largest, output valid_count,
                    output any_valid, input ready);
    modport sink   (input valid, input status, input read_value, input read_null,
                    input total, input smallest, input largest, input valid_count,
                    input any_valid, output ready);
endinterface

`default_nettype wire

FILE: rtl/nullable_typed_column_store_top.sv
// Top level of the nullable column store: sequencer, configuration registers,
// result register. Depends on ncs_pkg, ncs_in_if, ncs_out_if, ncs_ram, ncs_acc.
// Read, write value and write null pass through S_READ or S_MODIFY to the result.
// Reduce walks a non-empty column in S_WALK, one RAM entry per cycle, then S_FINISH.
// Throughput: one transaction at a time; ready stays low until the result is loaded
// and any pending result is taken. No transaction is accepted during the clearing
// pass over all DEPTH entries, one per cycle, after reset and defined config writes.
`default_nettype none

module nullable_typed_column_store_top #(
    parameter int DEPTH = ncs_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    ncs_in_if.sink                                    req,
    ncs_out_if.source                                 rsp,
    input  wire logic                                 cfg_we,
    input  wire logic [ncs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [ncs_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW   = ncs_pkg::ELEM_W;
    localparam int CW   = ncs_pkg::CNT_W;
    localparam int IW   = ncs_pkg::IDX_W;
    localparam int KW   = ncs_pkg::KIND_W;
    localparam int RW   = EW + 1;
    localparam logic [CW-1:0] LEN_MAX   = (DEPTH > 2047) ? {CW{1'b1}} : CW'(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MODIFY,
        S_WALK,
        S_FINISH
    } state_t;

    state_t                state_reg;
    logic [AW-1:0]         cnt_reg;
    logic [KW-1:0]         kind_reg;
    logic                  nulls_reg;
    logic [CW-1:0]         len_reg;
    logic [CW-1:0]         null_total_reg;
    ncs_pkg::op_t          op_reg;
    logic [IW-1:0]         idx_reg;
    logic [EW-1:0]         val_reg;

    logic                  out_valid_reg;
    ncs_pkg::status_t      status_reg;
    logic [EW-1:0]         read_value_reg;
    logic                  read_null_reg;
    logic [EW-1:0]         total_reg;
    logic [EW-1:0]         smallest_reg;
    logic [EW-1:0]         largest_reg;
    logic [CW-1:0]         valid_count_reg;
    logic                  any_valid_reg;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [RW-1:0]         ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [RW-1:0]         ram_rdata;

    ncs_pkg::acc_ctl_t     acc_ctl;
    logic signed [EW-1:0]  acc_sum;
    logic signed [EW-1:0]  acc_lo;
    logic signed [EW-1:0]  acc_hi;
    logic                  acc_found;

    logic                  accept;
    logic                  cfg_hit;
    logic                  in_range;
    logic                  elem_valid;
    logic                  value_fits;
    logic                  walk_last;
    ncs_pkg::status_t      mod_status;
    logic                  mod_we;
    logic [RW-1:0]         mod_wdata;
    logic [CW-1:0]         null_total_next;
    logic [CW-1:0]         nulls_cur;
    logic [CW-1:0]         nulls_mod;
    logic [CW-1:0]         vc_cur;
    logic [CW-1:0]         vc_mod;
    logic [CW-1:0]         len_next;

    function automatic logic [CW-1:0] valid_from(input logic [CW-1:0] len,
                                                 input logic [CW-1:0] nulls);
        return len - ((nulls > len) ? len : nulls);
    endfunction

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign cfg_hit   = cfg_we && (cfg_index == ncs_pkg::CFG_ELEM_KIND
                                  || cfg_index == ncs_pkg::CFG_NULLS_ALLOWED
                                  || cfg_index == ncs_pkg::CFG_COL_LENGTH);
    assign len_next  = (32'(cfg_data) > 32'(LEN_MAX)) ? LEN_MAX : cfg_data;

    assign in_range   = idx_reg < IW'(len_reg);
    assign elem_valid = !nulls_reg || ram_rdata[EW];
    assign walk_last  = (32'(cnt_reg) + 32'd1) == 32'(len_reg);

    always_comb
    begin
        case (kind_reg)
            ncs_pkg::KIND_INT8:  value_fits = val_reg == EW'($signed(val_reg[7:0]));
            ncs_pkg::KIND_INT16: value_fits = val_reg == EW'($signed(val_reg[15:0]));
            ncs_pkg::KIND_INT32: value_fits = val_reg == EW'($signed(val_reg[31:0]));
            ncs_pkg::KIND_BOOL:  value_fits = val_reg[EW-1:1] == '0;
            default:             value_fits = 1'b1;
        endcase
    end

    always_comb
    begin
        mod_status      = ncs_pkg::ST_OK;
        mod_we          = 1'b0;
        mod_wdata       = {1'b1, val_reg};
        null_total_next = null_total_reg;
        if (!in_range)
        begin
            mod_status = ncs_pkg::ST_INDEX_RANGE;
        end
        else if (op_reg == ncs_pkg::OP_WRITE_NULL)
        begin
            if (!nulls_reg)
            begin
                mod_status = ncs_pkg::ST_NULL_DENIED;
            end
            else if (ram_rdata[EW])
            begin
                mod_we          = 1'b1;
                mod_wdata       = {1'b0, {EW{1'b0}}};
                null_total_next = null_total_reg + CW'(1);
            end
        end
        else if (!value_fits)
        begin
            mod_status = ncs_pkg::ST_VALUE_RANGE;
        end
        else
        begin
            mod_we = 1'b1;
            if (nulls_reg && !ram_rdata[EW] && null_total_reg != '0)
            begin
                null_total_next = null_total_reg - CW'(1);
            end
        end
    end

    assign nulls_cur = nulls_reg ? null_total_reg : '0;
    assign nulls_mod = nulls_reg ? null_total_next : '0;
    assign vc_cur    = valid_from(len_reg, nulls_cur);
    assign vc_mod    = valid_from(len_reg, nulls_mod);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = {1'b1, {EW{1'b0}}};
        ram_raddr = cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_IDLE:
            begin
                ram_raddr = (ncs_pkg::op_t'(req.opcode) == ncs_pkg::OP_REDUCE)
                            ? '0 : req.elem_index[AW-1:0];
            end
            S_MODIFY:
            begin
                ram_we    = mod_we;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = mod_wdata;
            end
            S_WALK:
            begin
                ram_raddr = cnt_reg + AW'(1);
            end
            default:
            begin
                ram_raddr = cnt_reg;
            end
        endcase
    end

    assign acc_ctl.clear     = accept && (ncs_pkg::op_t'(req.opcode) == ncs_pkg::OP_REDUCE);
    assign acc_ctl.enable    = (state_reg == S_WALK) && elem_valid;
    assign acc_ctl.bool_mode = kind_reg == ncs_pkg::KIND_BOOL;

    ncs_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ncs_acc u_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (acc_ctl),
        .value (ram_rdata[EW-1:0]),
        .sum   (acc_sum),
        .lo    (acc_lo),
        .hi    (acc_hi),
        .found (acc_found)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            cnt_reg         <= '0;
            kind_reg        <= ncs_pkg::KIND_INT64;
            nulls_reg       <= 1'b0;
            len_reg         <= '0;
            null_total_reg  <= '0;
            op_reg          <= ncs_pkg::OP_WRITE_VALUE;
            idx_reg         <= '0;
            val_reg         <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ncs_pkg::ST_OK;
            read_value_reg  <= '0;
            read_null_reg   <= 1'b0;
            total_reg       <= '0;
            smallest_reg    <= '0;
            largest_reg     <= '0;
            valid_count_reg <= '0;
            any_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_hit)
            begin
                unique case (cfg_index)
                    ncs_pkg::CFG_ELEM_KIND:     kind_reg  <= cfg_data[KW-1:0];
                    ncs_pkg::CFG_NULLS_ALLOWED: nulls_reg <= cfg_data[0];
                    default:                    len_reg   <= len_next;
                endcase
                null_total_reg <= '0;
                cnt_reg        <= '0;
                state_reg      <= S_CLEAR;
            end
            else
            begin
                unique case (state_reg)
                    S_CLEAR:
                    begin
                        if (cnt_reg == LAST_ADDR)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + AW'(1);
                        end
                    end
                    S_IDLE:
                    begin
                        if (accept)
                        begin
                            op_reg  <= ncs_pkg::op_t'(req.opcode);
                            idx_reg <= req.elem_index;
                            val_reg <= req.write_value;
                            cnt_reg <= '0;
                            unique case (ncs_pkg::op_t'(req.opcode))
                                ncs_pkg::OP_READ:   state_reg <= S_READ;
                                ncs_pkg::OP_REDUCE: state_reg <= (len_reg == '0) ? S_FINISH
                                                                                : S_WALK;
                                default:            state_reg <= S_MODIFY;
                            endcase
                        end
                    end
                    S_READ:
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= ncs_pkg::ST_OK;
                        read_null_reg   <= !(in_range && elem_valid);
                        read_value_reg  <= (in_range && elem_valid) ? ram_rdata[EW-1:0] : '0;
                        total_reg       <= '0;
                        smallest_reg    <= '0;
                        largest_reg     <= '0;
                        any_valid_reg   <= 1'b0;
                        valid_count_reg <= vc_cur;
                        state_reg       <= S_IDLE;
                    end
                    S_MODIFY:
                    begin
                        null_total_reg  <= null_total_next;
                        out_valid_reg   <= 1'b1;
                        status_reg      <= mod_status;
                        read_null_reg   <= 1'b0;
                        read_value_reg  <= '0;
                        total_reg       <= '0;
                        smallest_reg    <= '0;
                        largest_reg     <= '0;
                        any_valid_reg   <= 1'b0;
                        valid_count_reg <= vc_mod;
                        state_reg       <= S_IDLE;
                    end
                    S_WALK:
                    begin
                        cnt_reg <= cnt_reg + AW'(1);
                        if (walk_last)
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                    S_FINISH:
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= ncs_pkg::ST_OK;
                        read_null_reg   <= 1'b0;
                        read_value_reg  <= '0;
                        total_reg       <= acc_sum;
                        smallest_reg    <= acc_found ? acc_lo : '0;
                        largest_reg     <= acc_found ? acc_hi : '0;
                        any_valid_reg   <= acc_found;
                        valid_count_reg <= vc_cur;
                        state_reg       <= S_IDLE;
                    end
                    default:
                    begin
                        state_reg <= S_CLEAR;
                    end
                endcase
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.read_value  = read_value_reg;
    assign rsp.read_null   = read_null_reg;
    assign rsp.total       = total_reg;
    assign rsp.smallest    = smallest_reg;
    assign rsp.largest     = largest_reg;
    assign rsp.valid_count = valid_count_reg;
    assign rsp.any_valid   = any_valid_reg;

    a_nulls_within_length: assert property (@(posedge clk) disable iff (!rst_n)
        null_total_reg <= len_reg)
        else $error("null count exceeds column length");

    a_walk_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> 32'(cnt_reg) < 32'(len_reg))
        else $error("reduce walk past column length");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_MODIFY || state_reg == S_FINISH)
        |-> !out_valid_reg)
        else $error("result loaded over a pending transaction");

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> !req.ready)
        else $error("transaction accepted right after a configuration write");

endmodule

`default_nettype wire

FILE: rtl/ncs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ncs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/ncs_acc.sv
// Reduce unit: wrapping sum, min/max (AND/OR for bool) and seen flag,
// advanced by one element per enabled cycle. Depends on ncs_pkg.
`default_nettype none

module ncs_acc (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ncs_pkg::acc_ctl_t                 ctl,
    input  wire logic signed [ncs_pkg::ELEM_W-1:0] value,
    output logic signed [ncs_pkg::ELEM_W-1:0]      sum,
    output logic signed [ncs_pkg::ELEM_W-1:0]      lo,
    output logic signed [ncs_pkg::ELEM_W-1:0]      hi,
    output logic                                   found
);

    logic signed [ncs_pkg::ELEM_W-1:0] sum_next;
    logic signed [ncs_pkg::ELEM_W-1:0] lo_next;
    logic signed [ncs_pkg::ELEM_W-1:0] hi_next;

    always_comb
    begin
        sum_next = sum + value;
        if (!found)
        begin
            lo_next = value;
            hi_next = value;
        end
        else if (ctl.bool_mode)
        begin
            lo_next = lo & value;
            hi_next = hi | value;
        end
        else
        begin
            lo_next = (value < lo) ? value : lo;
            hi_next = (value > hi) ? value : hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found <= 1'b0;
            sum   <= '0;
            lo    <= '0;
            hi    <= '0;
        end
        else if (ctl.clear)
        begin
            found <= 1'b0;
            sum   <= '0;
            lo    <= '0;
            hi    <= '0;
        end
        else if (ctl.enable)
        begin
            found <= 1'b1;
            sum   <= sum_next;
            lo    <= lo_next;
            hi    <= hi_next;
        end
    end

endmodule

`default_nettype wire
